>>> src/i2d_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
package i2d_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef logic [3:0] digit_t;

  localparam logic [1:0] OP_S32 = 2'd0;
  localparam logic [1:0] OP_U32 = 2'd1;
  localparam logic [1:0] OP_S64 = 2'd2;
  localparam logic [1:0] OP_U64 = 2'd3;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  localparam int CNT_W  = 5;
  localparam int STEP_W = 7;

  localparam logic [STEP_W-1:0] STEPS_32 = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_64 = 7'd64;

endpackage

>>> src/i2d_dabble.sv
// One shift-add-3 step of the binary to BCD conversion over the whole digit row.
module i2d_dabble import i2d_pkg::*; #(
  parameter int DIGITS = 20
) (
  input  digit_t [DIGITS-1:0] bcd_in,
  input  logic                shift_in,
  output digit_t [DIGITS-1:0] bcd_out,
  output logic                carry_out
);

  digit_t [DIGITS-1:0] adj;

  // Correct every digit of five or more before the doubling.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd_in[i] >= 4'd5) ? bcd_in[i] + 4'd3 : bcd_in[i];
    end
  end

  // Double and bring in the next magnitude bit; the top bit falls out as carry.
  assign {carry_out, bcd_out} = {adj, shift_in};

endmodule

>>> src/integer_to_decimal_ascii.sv
// Integer to decimal ASCII converter: top level with sequencer and output register.
// An item runs 32 shift-add steps (32-bit modes) or 64 (64-bit modes) through the
// shared BCD step unit and then a sizing step; its characters then go out one per
// cycle while out_ready stays high.
// in_ready is high only while idle; one item is in the block at a time.
// rst is synchronous and returns the sequencer to idle with no character pending.
module integer_to_decimal_ascii import i2d_pkg::*; #(
  parameter int MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_char,
  output logic        last,
  output logic [4:0]  char_count
);

  localparam int IDX_W = $clog2(MAX_DIGITS);

  state_t state, state_next;

  logic [63:0]                  mag, mag_next;
  digit_t [MAX_DIGITS-1:0]      bcd, bcd_next;
  logic                         ovf, ovf_next;
  logic                         neg, neg_next;
  logic [STEP_W-1:0]            steps, steps_next;
  logic [CNT_W-1:0]             dleft, dleft_next;
  logic [6:0]                   char_reg, char_reg_next;
  logic                         last_reg, last_reg_next;
  logic [CNT_W-1:0]             count_reg, count_reg_next;

  digit_t [MAX_DIGITS-1:0]      step_bcd;
  logic                         step_carry;
  logic [CNT_W-1:0]             digits_found;
  logic [CNT_W-1:0]             digits;
  logic [CNT_W-1:0]             pos_m1;
  logic [31:0]                  neg32;
  logic                         in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign neg32    = (~value[31:0]) + 32'd1;

  i2d_dabble #(.DIGITS(MAX_DIGITS)) u_dabble (
    .bcd_in    (bcd),
    .shift_in  (mag[63]),
    .bcd_out   (step_bcd),
    .carry_out (step_carry)
  );

  // Highest non-zero digit sets the length; zero still gives one digit.
  always_comb begin
    digits_found = CNT_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        digits_found = CNT_W'(i + 1);
      end
    end
  end

  assign digits = ovf ? CNT_W'(MAX_DIGITS) : digits_found;
  assign pos_m1 = dleft - CNT_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_CONV;
      ST_CONV: if (steps == STEP_W'(1)) state_next = ST_SIZE;
      ST_SIZE: state_next = ST_EMIT;
      ST_EMIT: if (out_fire && last_reg) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
  end

  assign out_char   = char_reg;
  assign last       = last_reg;
  assign char_count = count_reg;

  // Datapath
  always_comb begin
    mag_next       = mag;
    bcd_next       = bcd;
    ovf_next       = ovf;
    neg_next       = neg;
    steps_next     = steps;
    dleft_next     = dleft;
    char_reg_next  = char_reg;
    last_reg_next  = last_reg;
    count_reg_next = count_reg;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          bcd_next = '0;
          ovf_next = 1'b0;
          neg_next = 1'b0;
          unique case (opcode)
            OP_S32: begin
              neg_next   = value[31];
              mag_next   = {(value[31] ? neg32 : value[31:0]), 32'd0};
              steps_next = STEPS_32;
            end
            OP_U32: begin
              mag_next   = {value[31:0], 32'd0};
              steps_next = STEPS_32;
            end
            OP_S64: begin
              neg_next   = value[63];
              mag_next   = value[63] ? (~value) + 64'd1 : value;
              steps_next = STEPS_64;
            end
            OP_U64: begin
              mag_next   = value;
              steps_next = STEPS_64;
            end
            default: begin
              mag_next   = value;
              steps_next = STEPS_64;
            end
          endcase
        end
      end
      ST_CONV: begin
        bcd_next   = step_bcd;
        mag_next   = {mag[62:0], 1'b0};
        ovf_next   = ovf | step_carry;
        steps_next = steps - STEP_W'(1);
      end
      ST_SIZE: begin
        count_reg_next = digits + CNT_W'(neg);
        if (neg) begin
          char_reg_next = CHAR_MINUS;
          last_reg_next = 1'b0;
          dleft_next    = digits;
        end else begin
          char_reg_next = CHAR_ZERO + 7'(bcd[IDX_W'(digits - CNT_W'(1))]);
          last_reg_next = (digits == CNT_W'(1));
          dleft_next    = digits - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        // Advance to the next lower digit once the current character is taken.
        if (out_fire && !last_reg) begin
          char_reg_next = CHAR_ZERO + 7'(bcd[pos_m1[IDX_W-1:0]]);
          last_reg_next = (dleft == CNT_W'(1));
          dleft_next    = pos_m1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    bcd       <= bcd_next;
    ovf       <= ovf_next;
    neg       <= neg_next;
    steps     <= steps_next;
    dleft     <= dleft_next;
    char_reg  <= char_reg_next;
    last_reg  <= last_reg_next;
    count_reg <= count_reg_next;
  end

endmodule

>>> src/i2d_checker.sv
// Port-level assertions for the integer to decimal ASCII converter, bound to the top level.
module i2d_checker import i2d_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_char,
  input logic        last,
  input logic [4:0]  char_count
);

  // No new item is taken while characters are still going out.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("in_ready high while an item is being emitted");

  // After an accepted item the block is busy converting.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready still high after an item was accepted");

  // A character that is not the last one is followed by another.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid)
    else $error("item stream ended without a last flag");

  // The count stays the same across the characters of one number.
  a_count_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (char_count == $past(char_count)))
    else $error("char_count changed within one number");

  // Only a minus sign or a digit is emitted, with a count in range.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_char == CHAR_MINUS ||
                    (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 7'd9))
                   && char_count >= 5'd1 && char_count <= 5'd20))
    else $error("illegal character or count on output");

endmodule

bind integer_to_decimal_ascii i2d_checker u_i2d_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_char   (out_char),
  .last       (last),
  .char_count (char_count)
);

>>> verif/tb_integer_to_decimal_ascii.sv
// Self-checking testbench for the integer to decimal ASCII converter.
module tb_integer_to_decimal_ascii;
  import i2d_pkg::*;

  localparam int DIGITS_MAX = 20;
  localparam int IDLE_PCT   = 29;
  localparam int RANDOM_NUMBERS = 348;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] raw;
    logic        drain_first;
  } number_req_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
    logic [4:0] n;
  } text_char_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_S32;
  logic [63:0] value = 64'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_char;
  logic        last;
  logic [4:0]  char_count;

  number_req_t numbers_to_send[$];
  text_char_t  chars_due[$];
  int          numbers_open = 0;
  int          numbers_sent = 0;
  int unsigned mismatch_count = 0;
  logic        calm;

  // no idling on either side for a stretch of numbers
  assign calm = (numbers_sent >= 150) && (numbers_sent < 230);

  integer_to_decimal_ascii #(.MAX_DIGITS(DIGITS_MAX)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last       (last),
    .char_count (char_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the text of one number and queue its characters.
  function automatic void spell_decimal(input logic [1:0] op, input logic [63:0] raw);
    logic [63:0] mag;
    logic        neg;
    logic [3:0]  digs [DIGITS_MAX];
    int          n_dig;
    int          total;
    int          pos;
    text_char_t  c;
    neg = 1'b0;
    case (op)
      OP_S32: begin
        if (raw[31]) begin
          neg = 1'b1;
          mag = {32'd0, (~raw[31:0]) + 32'd1};
        end else begin
          mag = {32'd0, raw[31:0]};
        end
      end
      OP_U32: mag = {32'd0, raw[31:0]};
      OP_S64: begin
        if (raw[63]) begin
          neg = 1'b1;
          mag = (~raw) + 64'd1;
        end else begin
          mag = raw;
        end
      end
      default: mag = raw;
    endcase
    n_dig = 0;
    do begin
      digs[n_dig] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      n_dig++;
    end while (mag != 64'd0 && n_dig < DIGITS_MAX);
    total = n_dig + neg;
    if (neg) begin
      c.ch  = CHAR_MINUS;
      c.fin = (total == 1);
      c.n   = total[4:0];
      chars_due.push_back(c);
    end
    for (int k = neg; k < total; k++) begin
      pos   = total - 1 - k;
      c.ch  = CHAR_ZERO + {3'd0, digs[pos]};
      c.fin = (k + 1 == total);
      c.n   = total[4:0];
      chars_due.push_back(c);
    end
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] p;
    int          delta;
    case ($urandom_range(5))
      0, 1: pick_value = {$urandom, $urandom};
      2: pick_value = 64'($urandom_range(999));
      3: pick_value = {$urandom, $urandom} >> $urandom_range(63);
      4: pick_value = 64'd0 - 64'($urandom_range(1000));
      default: begin
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * 64'd10;
        delta = $urandom_range(2);
        pick_value = p + 64'(delta) - 64'd1;
      end
    endcase
  endfunction

  task automatic add_number(input logic [1:0] op, input logic [63:0] raw,
                            input logic drain);
    number_req_t r;
    r.op = op;
    r.raw = raw;
    r.drain_first = drain;
    numbers_to_send.push_back(r);
  endtask

  // Driver: hold each item until accepted, predict its text on acceptance.
  always @(posedge clk) begin : drive_numbers
    logic        took;
    logic        closed;
    int          open_now;
    number_req_t nxt;
    if (rst) begin
      in_valid     <= 1'b0;
      numbers_open <= 0;
      numbers_sent <= 0;
    end else begin
      took     = in_valid && in_ready;
      closed   = out_valid && out_ready && last;
      open_now = numbers_open + took - closed;
      if (took) spell_decimal(opcode, value);
      numbers_open <= open_now;
      numbers_sent <= numbers_sent + took;
      if (!in_valid || took) begin
        if (numbers_to_send.size() != 0 &&
            !(numbers_to_send[0].drain_first && open_now != 0) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = numbers_to_send.pop_front();
          in_valid <= 1'b1;
          opcode   <= nxt.op;
          value    <= nxt.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each character with the oldest one due.
  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (chars_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected character: expected none, actual char %0d last %0b count %0d",
                   $time, out_char, last, char_count);
        end else begin
          want = chars_due.pop_front();
          if (out_char !== want.ch) begin
            mismatch_count++;
            $display("%0t: out_char expected %0d actual %0d", $time, want.ch, out_char);
          end
          if (last !== want.fin) begin
            mismatch_count++;
            $display("%0t: last expected %0b actual %0b", $time, want.fin, last);
          end
          if (char_count !== want.n) begin
            mismatch_count++;
            $display("%0t: char_count expected %0d actual %0d", $time, want.n, char_count);
          end
        end
      end
    end
  end

  initial begin
    // extremes, upper bits ignored in 32-bit modes, most negative values
    add_number(OP_S32, 64'd0, 1'b0);
    add_number(OP_S32, 64'd1, 1'b0);
    add_number(OP_S32, 64'h0000_0000_FFFF_FFFF, 1'b0);
    add_number(OP_S32, 64'h0000_0000_7FFF_FFFF, 1'b0);
    add_number(OP_S32, 64'h0000_0000_8000_0000, 1'b0);
    add_number(OP_S32, 64'hDEAD_BEEF_0000_0000, 1'b0);
    add_number(OP_U32, 64'd0, 1'b0);
    add_number(OP_U32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_number(OP_U32, 64'h0000_0000_8000_0000, 1'b0);
    add_number(OP_U32, 64'hFFFF_FFFF_0000_000A, 1'b0);
    add_number(OP_S64, 64'd0, 1'b0);
    add_number(OP_S64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_number(OP_S64, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    add_number(OP_S64, 64'h8000_0000_0000_0000, 1'b0);
    add_number(OP_S64, 64'h8000_0000_0000_0001, 1'b0);
    add_number(OP_S64, 64'hFFFF_FFFF_8000_0000, 1'b0);
    add_number(OP_U64, 64'd0, 1'b0);
    add_number(OP_U64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_number(OP_U64, 64'h8000_0000_0000_0000, 1'b0);
    add_number(OP_U64, 64'd9999999999999999999, 1'b0);
    add_number(OP_U64, 64'd10000000000000000000, 1'b0);
    add_number(OP_U64, 64'd9, 1'b0);
    add_number(OP_U64, 64'd10, 1'b0);
    for (int i = 0; i < RANDOM_NUMBERS; i++)
      add_number(2'($urandom_range(3)), pick_value(), (i % 60) == 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (numbers_to_send.size() != 0 || in_valid || numbers_open != 0 ||
           chars_due.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
src/i2d_pkg.sv
src/i2d_dabble.sv
src/integer_to_decimal_ascii.sv
src/i2d_checker.sv
verif/tb_integer_to_decimal_ascii.sv
